// ----- rtl/core/dmcw_pkg.sv -----
// Shared types, codes and constants of the DMC walker engine.
package dmcw_pkg;

  localparam int unsigned MaxWalkersDef = 65536;
  localparam int unsigned HistBinsDef   = 128;
  localparam int unsigned MaxBranchDef  = 8;

  localparam logic [2:0] OpLoad    = 3'd0;
  localparam logic [2:0] OpMove    = 3'd1;
  localparam logic [2:0] OpEndGen  = 3'd2;
  localparam logic [2:0] OpReadBin = 3'd3;
  localparam logic [2:0] OpClear   = 3'd4;

  localparam logic [1:0] CfgTarget   = 2'd0;
  localparam logic [1:0] CfgTimeStep = 2'd1;
  localparam logic [1:0] CfgSqrtStep = 2'd2;
  localparam logic [1:0] CfgHistMax  = 2'd3;

  localparam logic [16:0] TargetRst   = 17'd300;
  localparam logic [15:0] TimeStepRst = 16'd3277;
  localparam logic [15:0] SqrtStepRst = 16'd14654;
  localparam logic [31:0] HistMaxRst  = 32'd655360;

  // log2(e) and ln(2) in Q16.16
  localparam logic signed [18:0] Log2eQ = 19'sd94548;
  localparam logic signed [16:0] Ln2Q   = 17'sd45426;
  // 2^f polynomial coefficients
  localparam logic [15:0] ExpC3 = 16'd5156;
  localparam logic [15:0] ExpC2 = 16'd14821;
  localparam logic [15:0] ExpC1 = 16'd45559;
  // floor(n/10) = (n * Div10Mul) >> Div10Shift for n < 2^32
  localparam logic [31:0] Div10Mul   = 32'd3435973837;
  localparam int unsigned Div10Shift = 35;
  // clamp of the exponent argument, Q16.16
  localparam logic signed [65:0] ExpArgMax = 66'sd1048576;
  localparam logic signed [65:0] ExpArgMin = -66'sd2097152;

  typedef struct packed {
    logic [2:0]         operation;
    logic [15:0]        walker_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [15:0]        branch_random;
  } in_t;

  typedef struct packed {
    logic [16:0]        population;
    logic signed [31:0] ground_energy;
    logic [3:0]         survivors;
    logic signed [63:0] energy_sum;
    logic [62:0]        energy_square_sum;
    logic [31:0]        generations;
    logic [31:0]        bin_count;
    logic               overflow;
  } out_t;

  typedef struct packed {
    logic               alive;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } walker_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = 32'(v);
    return r;
  endfunction

endpackage

// ----- rtl/core/dmcw_walker_mem.sv -----
// Walker store: position and alive mark, one write and one registered read port.
module dmcw_walker_mem import dmcw_pkg::*; #(
  parameter int unsigned Depth = MaxWalkersDef,
  localparam int unsigned Aw   = $clog2(Depth)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [Aw-1:0] waddr_i,
  input  walker_t       wdata_i,
  input  logic          re_i,
  input  logic [Aw-1:0] raddr_i,
  output walker_t       rdata_o
);

  walker_t mem_q [Depth];
  walker_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/dmcw_hist_mem.sv -----
// Radial histogram store, one write and one registered read port.
module dmcw_hist_mem import dmcw_pkg::*; #(
  parameter int unsigned Depth = HistBinsDef,
  localparam int unsigned Aw   = $clog2(Depth)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [Aw-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic          re_i,
  input  logic [Aw-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem_q [Depth];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/diffusion_monte_carlo_walkers.sv -----
// DMC walker engine top: command sequencer and datapath around the two stores.
// Load and unknown ops go straight to done, read bin reads one bin, move appends each extra
// copy, clear zeroes HIST_BINS bins, end of generation walks N then M kept walkers.
// One command at a time; busy_o stays high from accept until the done_o beat.
// Throughput is set by the sequencer walking the walker store through its single read port.
// Reset: async active low; a clearing pass over all HIST_BINS bins zeroes the histogram, busy high.
// Results are a one-cycle done_o beat; the receiver cannot stall.
module diffusion_monte_carlo_walkers import dmcw_pkg::*; #(
  parameter int unsigned MAX_WALKERS = MaxWalkersDef,
  parameter int unsigned HIST_BINS   = HistBinsDef,
  parameter int unsigned MAX_BRANCH  = MaxBranchDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  in_t         in_i,
  output logic        done_o,
  output out_t        res_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned CW  = $clog2(MAX_WALKERS + 1);
  localparam int unsigned AW  = $clog2(MAX_WALKERS);
  localparam int unsigned QB  = $clog2(HIST_BINS);
  localparam int unsigned SW  = $clog2(MAX_BRANCH + 1);
  localparam int unsigned LW  = (CW > 17) ? CW : 17;
  localparam int unsigned IXW = (CW > 16) ? CW : 16;
  localparam int unsigned DSW = $clog2(QB) + 1;
  localparam int unsigned NW  = 32 + QB;

  localparam logic [5:0] S_CLR  = 6'd0,  S_IDLE = 6'd1,  S_FIN  = 6'd2,  S_RBIN = 6'd3;
  localparam logic [5:0] S_MRD  = 6'd4,  S_MDX  = 6'd5,  S_MDY  = 6'd6,  S_MDZ  = 6'd7;
  localparam logic [5:0] S_MSX  = 6'd8,  S_MSY  = 6'd9,  S_MSZ  = 6'd10, S_MD   = 6'd11;
  localparam logic [5:0] S_MA   = 6'd12, S_MU   = 6'd13, S_MP1  = 6'd14, S_MP2  = 6'd15;
  localparam logic [5:0] S_MP3  = 6'd16, S_MQ   = 6'd17, S_MAPP = 6'd18, S_CRD  = 6'd19;
  localparam logic [5:0] S_CWR  = 6'd20, S_LN   = 6'd21, S_LI   = 6'd22, S_EW   = 6'd23;
  localparam logic [5:0] S_EDV  = 6'd24, S_EE0  = 6'd25, S_ESQ  = 6'd26, S_HRD  = 6'd27;
  localparam logic [5:0] S_HSX  = 6'd28, S_HSY  = 6'd29, S_HSZ  = 6'd30, S_HSQ  = 6'd31;
  localparam logic [5:0] S_HDI  = 6'd32, S_HDV  = 6'd33, S_HRB  = 6'd34;

  localparam logic [CW-1:0] CountMax = CW'(MAX_WALKERS);
  localparam logic [23:0]   QCap     = 24'(MAX_BRANCH) << 16;

  // control
  logic [5:0]    state_q, state_d;
  logic          clr_op_q, clr_op_d;
  logic [QB-1:0] clr_ptr_q, clr_ptr_d;
  logic [16:0]   tgt_q, tgt_d;
  logic [15:0]   ts_q, ts_d, sts_q, sts_d;
  logic [31:0]   hmr_q, hmr_d;
  logic [CW-1:0] count_q, count_d;
  logic signed [31:0] e0_q, e0_d;
  logic [63:0]   esum_q, esum_d, esq_q, esq_d;
  logic [31:0]   gen_q, gen_d;
  logic          lsel_q, lsel_d;

  // datapath
  logic [15:0]   idx_q, idx_d, rnd_q, rnd_d;
  logic signed [31:0] nx_q, nx_d, ny_q, ny_d, nz_q, nz_d;
  logic signed [31:0] px_q, px_d, py_q, py_d, pz_q, pz_d;
  logic [SW-1:0] surv_q, surv_d, cp_q, cp_d;
  logic [31:0]   bin_q, bin_d;
  logic          ovf_q, ovf_d;
  logic [63:0]   r2_q, r2_d;
  logic signed [48:0] d_q, d_d;
  logic signed [22:0] t_q, t_d;
  logic signed [9:0]  k_q, k_d;
  logic [15:0]   f_q, f_d;
  logic [16:0]   p_q, p_d;
  logic [CW-1:0] ci_q, ci_d, cj_q, cj_d, hi_q, hi_d;
  logic [4:0]    e_q, e_d;
  logic [16:0]   y_q, y_d;
  logic [15:0]   fr_q, fr_d;
  logic [3:0]    it_q, it_d;
  logic [20:0]   l1_q, l1_d, l2_q, l2_d;
  logic signed [23:0] w_q, w_d;
  logic signed [24:0] delta_q, delta_d;
  logic [63:0]   sv_q, sv_d, sr_q, sr_d;
  logic [4:0]    st_q, st_d;
  logic [31:0]   r_q, r_d, rem_q, rem_d;
  logic [QB-1:0] dlo_q, dlo_d, quo_q, quo_d, hb_q, hb_d;
  logic [DSW-1:0] dstep_q, dstep_d;

  // memory ports
  logic          w_we, w_re;
  logic [AW-1:0] w_waddr, w_raddr;
  walker_t       w_wdata, w_rdata;
  logic          h_we, h_re;
  logic [QB-1:0] h_waddr, h_raddr;
  logic [31:0]   h_wdata, h_rdata;

  // shared arithmetic
  logic signed [31:0] sq_op;
  logic signed [63:0] sq_full;
  logic signed [31:0] n_sel, p_sel, new_pos;
  logic signed [48:0] nmul;
  logic signed [65:0] a_prod, a_shr, t_neg;
  logic signed [41:0] u_prod;
  logic [17:0]   pc;
  logic [33:0]   pmul;
  logic [17:0]   mval;
  logic signed [9:0] nk;
  logic [23:0]   qv;
  logic [7:0]    surv_c;
  logic [LW-1:0] lx;
  logic [4:0]    lmsb;
  logic [33:0]   y2_full;
  logic [17:0]   y2;
  logic [20:0]   lnew;
  logic signed [21:0] dl;
  logic signed [38:0] wp;
  logic [23:0]   wmag;
  logic [55:0]   dv_prod;
  logic [20:0]   qm;
  logic [5:0]    sq_sh;
  logic [63:0]   sq_bit, sq_sum;
  logic [NW-1:0] dn;
  logic [32:0]   rem2;
  logic          rem_ge;
  logic          acc;
  logic [IXW-1:0] idx_w, in_idx_w, count_w;

  dmcw_walker_mem #(.Depth(MAX_WALKERS)) u_walkers (
    .clk_i, .we_i(w_we), .waddr_i(w_waddr), .wdata_i(w_wdata),
    .re_i(w_re), .raddr_i(w_raddr), .rdata_o(w_rdata)
  );

  dmcw_hist_mem #(.Depth(HIST_BINS)) u_hist (
    .clk_i, .we_i(h_we), .waddr_i(h_waddr), .wdata_i(h_wdata),
    .re_i(h_re), .raddr_i(h_raddr), .rdata_o(h_rdata)
  );

  assign acc      = start_i && (state_q == S_IDLE);
  assign idx_w    = IXW'(idx_q);
  assign in_idx_w = IXW'(in_i.walker_index);
  assign count_w  = IXW'(count_q);

  // square unit shared by move, radius and energy accumulation
  always_comb begin
    case (state_q)
      S_MSX:   sq_op = px_q;
      S_MSY:   sq_op = py_q;
      S_MSZ:   sq_op = pz_q;
      S_HSX:   sq_op = w_rdata.x;
      S_HSY:   sq_op = w_rdata.y;
      S_HSZ:   sq_op = w_rdata.z;
      default: sq_op = e0_q;
    endcase
  end
  assign sq_full = sq_op * sq_op;

  // diffusion step
  always_comb begin
    case (state_q)
      S_MDX:   begin n_sel = nx_q; p_sel = px_q; end
      S_MDY:   begin n_sel = ny_q; p_sel = py_q; end
      default: begin n_sel = nz_q; p_sel = pz_q; end
    endcase
  end
  assign nmul    = n_sel * $signed({1'b0, sts_q});
  assign new_pos = sat32(64'(p_sel) + 64'(nmul >>> 16));

  // exponent argument, 2^f polynomial and stochastic rounding
  assign a_prod = d_q * $signed({1'b0, ts_q});
  assign a_shr  = a_prod >>> 16;
  assign t_neg  = -a_shr;
  assign u_prod = t_q * Log2eQ;
  assign pc     = (state_q == S_MP1) ? 18'(ExpC3) :
                  (state_q == S_MP2) ? 18'(ExpC2) + 18'(p_q) : 18'(ExpC1) + 18'(p_q);
  assign pmul   = 34'(f_q) * 34'(pc);
  assign mval   = 18'd65536 + 18'(p_q);
  assign nk     = -k_q;

  always_comb begin
    if (!k_q[9] && (k_q >= 10'sd7)) qv = QCap;
    else if (!k_q[9]) qv = 24'(mval) << k_q[2:0];
    else if (nk >= 10'sd32) qv = '0;
    else qv = 24'(mval) >> nk[4:0];
    if (qv > QCap) qv = QCap;
  end
  assign surv_c = qv[23:16] + 8'(qv[15:0] > rnd_q);

  // log2: top set bit, normalized mantissa squared per step
  assign lx = lsel_q ? ((count_q == '0) ? LW'(1) : LW'(count_q))
                     : ((tgt_q == '0) ? LW'(1) : LW'(tgt_q));
  always_comb begin
    lmsb = '0;
    for (int i = 0; i < LW; i++) begin
      if (lx[i]) lmsb = 5'(i);
    end
  end
  assign y2_full = 34'(y_q) * 34'(y_q);
  assign y2      = y2_full[33:16];
  assign lnew    = {e_q, fr_q[14:0], y2[17]};

  // energy feedback
  assign dl      = $signed({1'b0, l1_q}) - $signed({1'b0, l2_q});
  assign wp      = dl * Ln2Q;
  assign wmag    = w_q[23] ? 24'(-w_q) : 24'(w_q);
  assign dv_prod = 56'(wmag) * 56'(Div10Mul);
  assign qm      = 21'(dv_prod >> Div10Shift);

  // radius square root and bin division
  assign sq_sh  = 6'd62 - {st_q, 1'b0};
  assign sq_bit = 64'd1 << sq_sh;
  assign sq_sum = sr_q + sq_bit;
  assign dn     = NW'(r_q) * NW'(HIST_BINS);
  assign rem2   = {rem_q, dlo_q[QB-1]};
  assign rem_ge = rem2 >= {1'b0, hmr_q};

  always_comb begin
    state_d = state_q;  clr_op_d = clr_op_q; clr_ptr_d = clr_ptr_q;
    tgt_d = tgt_q; ts_d = ts_q; sts_d = sts_q; hmr_d = hmr_q;
    count_d = count_q; e0_d = e0_q; esum_d = esum_q; esq_d = esq_q; gen_d = gen_q;
    lsel_d = lsel_q;
    idx_d = idx_q; rnd_d = rnd_q; nx_d = nx_q; ny_d = ny_q; nz_d = nz_q;
    px_d = px_q; py_d = py_q; pz_d = pz_q;
    surv_d = surv_q; cp_d = cp_q; bin_d = bin_q; ovf_d = ovf_q;
    r2_d = r2_q; d_d = d_q; t_d = t_q; k_d = k_q; f_d = f_q; p_d = p_q;
    ci_d = ci_q; cj_d = cj_q; hi_d = hi_q;
    e_d = e_q; y_d = y_q; fr_d = fr_q; it_d = it_q; l1_d = l1_q; l2_d = l2_q;
    w_d = w_q; delta_d = delta_q;
    sv_d = sv_q; sr_d = sr_q; st_d = st_q; r_d = r_q;
    rem_d = rem_q; dlo_d = dlo_q; quo_d = quo_q; hb_d = hb_q; dstep_d = dstep_q;
    w_we = 1'b0; w_waddr = count_q[AW-1:0]; w_wdata = '0;
    w_re = 1'b0; w_raddr = ci_q[AW-1:0];
    h_we = 1'b0; h_waddr = clr_ptr_q; h_wdata = '0;
    h_re = 1'b0; h_raddr = in_i.walker_index[QB-1:0];

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgTarget:   tgt_d = cfg_data_i[16:0];
        CfgTimeStep: ts_d  = cfg_data_i[15:0];
        CfgSqrtStep: sts_d = cfg_data_i[15:0];
        CfgHistMax:  hmr_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      S_CLR: begin
        h_we = 1'b1;
        if (clr_ptr_q == QB'(HIST_BINS - 1)) begin
          state_d = clr_op_q ? S_FIN : S_IDLE;
        end else begin
          clr_ptr_d = clr_ptr_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (acc) begin
          idx_d = in_i.walker_index; rnd_d = in_i.branch_random;
          nx_d = in_i.coord_x; ny_d = in_i.coord_y; nz_d = in_i.coord_z;
          surv_d = '0; bin_d = '0; ovf_d = 1'b0;
          state_d = S_FIN;
          case (in_i.operation)
            OpLoad: begin
              if (count_q == CountMax) begin
                ovf_d = 1'b1;
              end else begin
                w_we = 1'b1;
                w_wdata = {1'b1, in_i.coord_x, in_i.coord_y, in_i.coord_z};
                count_d = count_q + 1'b1;
              end
            end
            OpMove: begin
              if (in_idx_w < count_w) begin
                w_re = 1'b1;
                w_raddr = in_idx_w[AW-1:0];
                state_d = S_MRD;
              end
            end
            OpEndGen: begin
              ci_d = '0; cj_d = '0; lsel_d = 1'b0;
              state_d = (count_q == '0) ? S_LN : S_CRD;
            end
            OpReadBin: begin
              if (in_i.walker_index < 16'(HIST_BINS)) begin
                h_re = 1'b1;
                state_d = S_RBIN;
              end
            end
            OpClear: begin
              esum_d = '0; esq_d = '0; gen_d = '0;
              clr_op_d = 1'b1; clr_ptr_d = '0;
              state_d = S_CLR;
            end
            default: ;
          endcase
        end
      end
      S_FIN: begin
        clr_op_d = 1'b0;
        state_d = S_IDLE;
      end
      S_RBIN: begin
        bin_d = h_rdata;
        state_d = S_FIN;
      end
      // move
      S_MRD: begin
        px_d = w_rdata.x; py_d = w_rdata.y; pz_d = w_rdata.z;
        state_d = w_rdata.alive ? S_MDX : S_FIN;
      end
      S_MDX: begin px_d = new_pos; state_d = S_MDY; end
      S_MDY: begin py_d = new_pos; state_d = S_MDZ; end
      S_MDZ: begin pz_d = new_pos; state_d = S_MSX; end
      S_MSX: begin r2_d = sq_full; state_d = S_MSY; end
      S_MSY: begin r2_d = r2_q + sq_full; state_d = S_MSZ; end
      S_MSZ: begin r2_d = r2_q + sq_full; state_d = S_MD; end
      S_MD: begin
        d_d = $signed({2'b0, r2_q[63:17]}) - 49'(e0_q);
        state_d = S_MA;
      end
      S_MA: begin
        if (t_neg > ExpArgMax) t_d = 23'(ExpArgMax);
        else if (t_neg < ExpArgMin) t_d = 23'(ExpArgMin);
        else t_d = 23'(t_neg);
        state_d = S_MU;
      end
      S_MU: begin
        k_d = 10'(u_prod >>> 32);
        f_d = u_prod[31:16];
        state_d = S_MP1;
      end
      S_MP1: begin p_d = 17'(pmul >> 16); state_d = S_MP2; end
      S_MP2: begin p_d = 17'(pmul >> 16); state_d = S_MP3; end
      S_MP3: begin p_d = 17'(pmul >> 16); state_d = S_MQ; end
      S_MQ: begin
        surv_d = SW'(surv_c);
        cp_d = SW'(surv_c - 8'd1);
        w_we = 1'b1;
        w_waddr = idx_w[AW-1:0];
        w_wdata = {(surv_c != 8'd0), px_q, py_q, pz_q};
        state_d = (surv_c > 8'd1) ? S_MAPP : S_FIN;
      end
      S_MAPP: begin
        if (count_q == CountMax) begin
          ovf_d = 1'b1;
        end else begin
          w_we = 1'b1;
          w_wdata = {1'b1, px_q, py_q, pz_q};
          count_d = count_q + 1'b1;
        end
        if (cp_q == SW'(1)) state_d = S_FIN;
        else cp_d = cp_q - 1'b1;
      end
      // compaction: read entry i, copy it down to j when alive
      S_CRD: begin
        w_re = 1'b1;
        state_d = S_CWR;
      end
      S_CWR: begin
        if (w_rdata.alive) begin
          w_we = 1'b1;
          w_waddr = cj_q[AW-1:0];
          w_wdata = w_rdata;
          cj_d = cj_q + 1'b1;
        end
        if ((ci_q + CW'(1)) == count_q) begin
          count_d = cj_d;
          state_d = S_LN;
        end else begin
          ci_d = ci_q + 1'b1;
          state_d = S_CRD;
        end
      end
      // log2 of target, then of population
      S_LN: begin
        e_d = lmsb;
        if (lmsb >= 5'd16) y_d = 17'(lx >> (lmsb - 5'd16));
        else y_d = 17'({16'b0, lx} << (5'd16 - lmsb));
        fr_d = '0;
        it_d = '0;
        state_d = S_LI;
      end
      S_LI: begin
        y_d = y2[17] ? y2[17:1] : y2[16:0];
        fr_d = {fr_q[14:0], y2[17]};
        it_d = it_q + 1'b1;
        if (it_q == 4'd15) begin
          if (!lsel_q) begin
            l1_d = lnew;
            lsel_d = 1'b1;
            state_d = S_LN;
          end else begin
            l2_d = lnew;
            state_d = S_EW;
          end
        end
      end
      S_EW: begin
        w_d = 24'(wp >>> 16);
        state_d = S_EDV;
      end
      S_EDV: begin
        delta_d = w_q[23] ? -$signed({4'b0, qm}) : $signed({4'b0, qm});
        state_d = S_EE0;
      end
      S_EE0: begin
        e0_d = sat32(64'(e0_q) + 64'(delta_q));
        state_d = S_ESQ;
      end
      S_ESQ: begin
        esq_d = esq_q + 64'(sq_full);
        esum_d = esum_q + 64'(e0_q);
        gen_d = gen_q + 1'b1;
        hi_d = '0;
        state_d = ((hmr_q != '0) && (count_q != '0)) ? S_HRD : S_FIN;
      end
      // histogram pass
      S_HRD: begin
        w_re = 1'b1;
        w_raddr = hi_q[AW-1:0];
        state_d = S_HSX;
      end
      S_HSX: begin r2_d = sq_full; state_d = S_HSY; end
      S_HSY: begin r2_d = r2_q + sq_full; state_d = S_HSZ; end
      S_HSZ: begin
        sv_d = r2_q + sq_full;
        sr_d = '0;
        st_d = '0;
        state_d = S_HSQ;
      end
      S_HSQ: begin
        if (sv_q >= sq_sum) begin
          sv_d = sv_q - sq_sum;
          sr_d = (sr_q >> 1) + sq_bit;
        end else begin
          sr_d = sr_q >> 1;
        end
        st_d = st_q + 1'b1;
        if (st_q == 5'd31) begin
          r_d = sr_d[31:0];
          state_d = S_HDI;
        end
      end
      S_HDI: begin
        if (r_q >= hmr_q) begin
          // radius beyond the last bin
          if ((hi_q + CW'(1)) == count_q) state_d = S_FIN;
          else begin
            hi_d = hi_q + 1'b1;
            state_d = S_HRD;
          end
        end else begin
          rem_d = 32'(dn >> QB);
          dlo_d = dn[QB-1:0];
          quo_d = '0;
          dstep_d = '0;
          state_d = S_HDV;
        end
      end
      S_HDV: begin
        rem_d = rem_ge ? 32'(rem2 - {1'b0, hmr_q}) : 32'(rem2);
        quo_d = {quo_q[QB-2:0], rem_ge};
        dlo_d = {dlo_q[QB-2:0], 1'b0};
        dstep_d = dstep_q + 1'b1;
        if (dstep_q == DSW'(QB - 1)) begin
          hb_d = quo_d;
          h_re = 1'b1;
          h_raddr = quo_d;
          state_d = S_HRB;
        end
      end
      S_HRB: begin
        h_we = 1'b1;
        h_waddr = hb_q;
        h_wdata = h_rdata + 32'd1;
        if ((hi_q + CW'(1)) == count_q) state_d = S_FIN;
        else begin
          hi_d = hi_q + 1'b1;
          state_d = S_HRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      clr_op_q  <= 1'b0;
      clr_ptr_q <= '0;
      tgt_q     <= TargetRst;
      ts_q      <= TimeStepRst;
      sts_q     <= SqrtStepRst;
      hmr_q     <= HistMaxRst;
      count_q   <= '0;
      e0_q      <= '0;
      esum_q    <= '0;
      esq_q     <= '0;
      gen_q     <= '0;
      lsel_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_op_q  <= clr_op_d;
      clr_ptr_q <= clr_ptr_d;
      tgt_q     <= tgt_d;
      ts_q      <= ts_d;
      sts_q     <= sts_d;
      hmr_q     <= hmr_d;
      count_q   <= count_d;
      e0_q      <= e0_d;
      esum_q    <= esum_d;
      esq_q     <= esq_d;
      gen_q     <= gen_d;
      lsel_q    <= lsel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; rnd_q <= rnd_d; nx_q <= nx_d; ny_q <= ny_d; nz_q <= nz_d;
    px_q <= px_d; py_q <= py_d; pz_q <= pz_d;
    surv_q <= surv_d; cp_q <= cp_d; bin_q <= bin_d; ovf_q <= ovf_d;
    r2_q <= r2_d; d_q <= d_d; t_q <= t_d; k_q <= k_d; f_q <= f_d; p_q <= p_d;
    ci_q <= ci_d; cj_q <= cj_d; hi_q <= hi_d;
    e_q <= e_d; y_q <= y_d; fr_q <= fr_d; it_q <= it_d; l1_q <= l1_d; l2_q <= l2_d;
    w_q <= w_d; delta_q <= delta_d;
    sv_q <= sv_d; sr_q <= sr_d; st_q <= st_d; r_q <= r_d;
    rem_q <= rem_d; dlo_q <= dlo_d; quo_q <= quo_d; hb_q <= hb_d; dstep_q <= dstep_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_FIN);

  always_comb begin
    res_o.population        = 17'(count_q);
    res_o.ground_energy     = e0_q;
    res_o.survivors         = 4'(surv_q);
    res_o.energy_sum        = esum_q;
    res_o.energy_square_sum = esq_q[62:0];
    res_o.generations       = gen_q;
    res_o.bin_count         = bin_q;
    res_o.overflow          = ovf_q;
  end

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the DMC walker engine: directed table, then random phases.
`timescale 1ns / 1ps

module tb;
  import dmcw_pkg::*;

  localparam int unsigned MaxW  = MaxWalkersDef;
  localparam int unsigned Bins  = HistBinsDef;
  localparam int unsigned MaxBr = MaxBranchDef;
  localparam logic [2:0] OpUnused5 = 3'd5;
  localparam logic [2:0] OpUnused6 = 3'd6;
  localparam logic [2:0] OpUnused7 = 3'd7;
  localparam int unsigned QuietLimit = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  in_t         in_i;
  logic        done_o;
  out_t        res_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;

  diffusion_monte_carlo_walkers dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .in_i, .done_o, .res_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // shadow copy of the engine state
  logic signed [31:0] wx [MaxW];
  logic signed [31:0] wy [MaxW];
  logic signed [31:0] wz [MaxW];
  bit                 walive [MaxW];
  int unsigned        wcount;
  logic signed [31:0] e_ref;
  logic [63:0]        e_sum, e_sq;
  logic [31:0]        gen_cnt;
  logic [31:0]        rad_hist [Bins];
  logic [16:0]        cfg_target;
  logic [15:0]        cfg_dt, cfg_sqdt;
  logic [31:0]        cfg_rmax;

  out_t        pending_results[$];
  int unsigned fails;
  int unsigned idle_pct;
  int unsigned quiet;

  function automatic logic signed [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] square(input logic signed [31:0] v);
    return longint'(v) * longint'(v);
  endfunction

  function automatic logic [31:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r[31:0];
  endfunction

  // log2 in Q16.16, fraction by repeated squaring
  function automatic longint log2_q16(input logic [31:0] x);
    int unsigned e;
    logic [63:0] y, frac;
    if (x == 0) x = 1;
    e = 0;
    while (e < 31 && (x >> (e + 1)) != 0) e++;
    y = (e >= 16) ? (64'(x) >> (e - 16)) : (64'(x) << (16 - e));
    frac = 0;
    for (int i = 0; i < 16; i++) begin
      y = (y * y) >> 16;
      frac <<= 1;
      if (y >= 64'd131072) begin
        y >>= 1;
        frac |= 1;
      end
    end
    return longint'((64'(e) << 16) | frac);
  endfunction

  function automatic bit add_walker(input logic signed [31:0] x, y, z);
    if (wcount >= MaxW) return 1'b1;
    wx[wcount] = x;
    wy[wcount] = y;
    wz[wcount] = z;
    walive[wcount] = 1'b1;
    wcount++;
    return 1'b0;
  endfunction

  function automatic int unsigned diffuse_and_branch(input in_t it, output bit ovf);
    longint s, v, a, t, u, k;
    logic [63:0] f, m, q, cap, u_bits;
    logic signed [31:0] x, y, z;
    int unsigned n, surv;
    ovf = 1'b0;
    n = it.walker_index;
    if (n >= wcount || !walive[n]) return 0;
    s = longint'(cfg_sqdt);
    x = clip32(longint'(wx[n]) + ((longint'(it.coord_x) * s) >>> 16));
    y = clip32(longint'(wy[n]) + ((longint'(it.coord_y) * s) >>> 16));
    z = clip32(longint'(wz[n]) + ((longint'(it.coord_z) * s) >>> 16));
    wx[n] = x;
    wy[n] = y;
    wz[n] = z;
    v = longint'((square(x) + square(y) + square(z)) >> 17);
    a = (longint'(cfg_dt) * (v - longint'(e_ref))) >>> 16;
    t = -a;
    if (t > (longint'(16) << 16)) t = longint'(16) << 16;
    if (t < -(longint'(32) << 16)) t = -(longint'(32) << 16);
    u = (t * 94548) >>> 16;
    k = u >>> 16;
    u_bits = u;
    f = u_bits & 64'hFFFF;
    m = 64'd65536 + ((f * (64'd45559 + ((f * (64'd14821 + ((f * 64'd5156) >> 16))) >> 16)))
        >> 16);
    cap = 64'(MaxBr) << 16;
    if (k >= 7) q = cap;
    else if (k >= 0) q = m << k;
    else if (-k >= 32) q = 0;
    else q = m >> (-k);
    if (q > cap) q = cap;
    surv = q >> 16;
    if (q[15:0] > it.branch_random) surv++;
    for (int unsigned i = 1; i < surv; i++)
      if (add_walker(x, y, z)) ovf = 1'b1;
    if (surv == 0) walive[n] = 1'b0;
    return surv;
  endfunction

  function automatic void close_generation();
    int unsigned j;
    longint d, delta;
    logic [63:0] bin;
    j = 0;
    for (int unsigned i = 0; i < wcount; i++) begin
      if (walive[i]) begin
        wx[j] = wx[i];
        wy[j] = wy[i];
        wz[j] = wz[i];
        walive[j] = 1'b1;
        j++;
      end
    end
    for (int unsigned i = j; i < wcount; i++) walive[i] = 1'b0;
    wcount = j;
    d = log2_q16(cfg_target != 0 ? 32'(cfg_target) : 32'd1) - log2_q16(j != 0 ? j : 1);
    delta = ((d * 45426) >>> 16) / 10;
    e_ref = clip32(longint'(e_ref) + delta);
    e_sum += longint'(e_ref);
    e_sq += square(e_ref);
    if (cfg_rmax != 0) begin
      for (int unsigned i = 0; i < wcount; i++) begin
        bin = (64'(int_sqrt(square(wx[i]) + square(wy[i]) + square(wz[i]))) * Bins)
              / 64'(cfg_rmax);
        if (bin < Bins) rad_hist[bin]++;
      end
    end
    gen_cnt++;
  endfunction

  function automatic out_t walker_engine_step(input in_t it);
    out_t o;
    bit ovf;
    int unsigned surv;
    logic [31:0] bin;
    ovf = 1'b0;
    surv = 0;
    bin = 0;
    case (it.operation)
      OpLoad:    ovf = add_walker(it.coord_x, it.coord_y, it.coord_z);
      OpMove:    surv = diffuse_and_branch(it, ovf);
      OpEndGen:  close_generation();
      OpReadBin: if (it.walker_index < Bins) bin = rad_hist[it.walker_index];
      OpClear: begin
        e_sum = 0;
        e_sq = 0;
        gen_cnt = 0;
        for (int i = 0; i < Bins; i++) rad_hist[i] = 0;
      end
      default: ;
    endcase
    o.population = wcount[16:0];
    o.ground_energy = e_ref;
    o.survivors = surv[3:0];
    o.energy_sum = e_sum;
    o.energy_square_sum = e_sq[62:0];
    o.generations = gen_cnt;
    o.bin_count = bin;
    o.overflow = ovf;
    return o;
  endfunction

  // result checker: the receiver never stalls, a done beat is always taken
  always @(posedge clk_i) begin
    out_t w;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        fails++;
      end else begin
        w = pending_results.pop_front();
        if (res_o.population !== w.population) begin
          $error("population exp %0d got %0d", w.population, res_o.population); fails++;
        end
        if (res_o.ground_energy !== w.ground_energy) begin
          $error("ground_energy exp %0d got %0d", w.ground_energy, res_o.ground_energy);
          fails++;
        end
        if (res_o.survivors !== w.survivors) begin
          $error("survivors exp %0d got %0d", w.survivors, res_o.survivors); fails++;
        end
        if (res_o.energy_sum !== w.energy_sum) begin
          $error("energy_sum exp %0d got %0d", w.energy_sum, res_o.energy_sum); fails++;
        end
        if (res_o.energy_square_sum !== w.energy_square_sum) begin
          $error("energy_square_sum exp %0d got %0d", w.energy_square_sum,
                 res_o.energy_square_sum);
          fails++;
        end
        if (res_o.generations !== w.generations) begin
          $error("generations exp %0d got %0d", w.generations, res_o.generations); fails++;
        end
        if (res_o.bin_count !== w.bin_count) begin
          $error("bin_count exp %0d got %0d", w.bin_count, res_o.bin_count); fails++;
        end
        if (res_o.overflow !== w.overflow) begin
          $error("overflow exp %0d got %0d", w.overflow, res_o.overflow); fails++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic issue(input in_t it, input bit typed, input out_t want);
    out_t p;
    start_i <= 1'b1;
    in_i <= it;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    p = walker_engine_step(it);
    pending_results.push_back(typed ? want : p);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0 || busy_o) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CfgTarget:   cfg_target = val[16:0];
      CfgTimeStep: cfg_dt = val[15:0];
      CfgSqrtStep: cfg_sqdt = val[15:0];
      CfgHistMax:  cfg_rmax = val;
      default: ;
    endcase
  endtask

  function automatic in_t mk(input logic [2:0] op, input logic [15:0] idx,
                             input logic [31:0] x, y, z, input logic [15:0] rnd);
    in_t it;
    it.operation = op;
    it.walker_index = idx;
    it.coord_x = x;
    it.coord_y = y;
    it.coord_z = z;
    it.branch_random = rnd;
    return it;
  endfunction

  // coordinate within +-lim units, or any 32-bit value now and then
  function automatic logic [31:0] coord(input int unsigned lim);
    if ($urandom_range(9) == 0) return $urandom;
    return 32'($signed($urandom_range(2 * lim * 65536)) - $signed(lim * 65536));
  endfunction

  function automatic in_t random_item();
    int unsigned sel;
    logic [15:0] idx;
    logic [2:0] op;
    sel = $urandom_range(99);
    idx = (wcount != 0 && $urandom_range(9) != 0) ? 16'($urandom_range(wcount - 1))
                                                   : 16'($urandom);
    if (wcount > 200) begin
      // hold the population: only commands that cannot grow it
      op = (sel < 40) ? OpEndGen : (sel < 80) ? OpReadBin : OpUnused6;
      return mk(op, 16'($urandom_range(Bins)), coord(8), coord(8), coord(8), $urandom);
    end
    if (wcount > 100 && sel < 50)
      return mk(OpMove, idx, 32'h40000000, 32'hC0000000, 32'h40000000, $urandom);
    if (sel < 22 || wcount == 0) op = OpLoad;
    else if (sel < 70) op = OpMove;
    else if (sel < 80) op = OpEndGen;
    else if (sel < 90) op = OpReadBin;
    else if (sel < 93) op = OpClear;
    else op = 3'($urandom_range(5, 7));
    if (op == OpReadBin) idx = ($urandom_range(9) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(Bins - 1));
    if (op == OpMove) return mk(op, idx, coord(3), coord(3), coord(3), $urandom);
    return mk(op, idx, coord(6), coord(6), coord(6), $urandom);
  endfunction

  typedef struct {
    in_t  item;
    bit   typed;
    out_t want;
  } stim_row_t;

  typedef struct {
    int unsigned idle;
    logic [31:0] target, dt, sqdt, rmax;
  } phase_t;

  initial begin
    stim_row_t rows[$];
    phase_t    phases[4];
    out_t      none;

    start_i = 1'b0;
    in_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgTarget;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    fails = 0;
    quiet = 0;
    idle_pct = 15;
    wcount = 0;
    e_ref = 0;
    e_sum = 0;
    e_sq = 0;
    gen_cnt = 0;
    for (int i = 0; i < Bins; i++) rad_hist[i] = 0;
    for (int i = 0; i < MaxW; i++) walive[i] = 1'b0;
    cfg_target = TargetRst;
    cfg_dt = TimeStepRst;
    cfg_sqdt = SqrtStepRst;
    cfg_rmax = HistMaxRst;
    none = '0;

    rows = '{
      '{mk(OpReadBin, 16'd0, 0, 0, 0, 0), 1'b1, none},
      '{mk(OpUnused5, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF), 1'b1, none},
      '{mk(OpUnused7, 16'd3, 1, 2, 3, 4), 1'b1, none},
      '{mk(OpMove, 16'd0, 32'h10000, 0, 0, 0), 1'b1, none},
      '{mk(OpEndGen, 0, 0, 0, 0, 0), 1'b0, none},
      '{mk(OpLoad, 0, 0, 0, 0, 0), 1'b0, none},
      '{mk(OpLoad, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0), 1'b0, none},
      '{mk(OpLoad, 0, 32'h80000000, 32'h80000000, 32'h80000000, 0), 1'b0, none},
      '{mk(OpLoad, 0, 32'h10000, 32'h20000, 32'hFFFF0000, 0), 1'b0, none},
      '{mk(OpMove, 16'd0, 0, 0, 0, 16'd0), 1'b0, none},
      '{mk(OpMove, 16'd1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF), 1'b0, none},
      '{mk(OpMove, 16'd2, 32'h80000000, 32'h80000000, 32'h80000000, 16'd0), 1'b0, none},
      '{mk(OpMove, 16'd3, 32'h10000, 32'hFFFF0000, 0, 16'h8000), 1'b0, none},
      '{mk(OpMove, 16'd200, 0, 0, 0, 0), 1'b0, none},
      '{mk(OpEndGen, 0, 0, 0, 0, 0), 1'b0, none},
      '{mk(OpReadBin, 16'd0, 0, 0, 0, 0), 1'b0, none},
      '{mk(OpReadBin, 16'd127, 0, 0, 0, 0), 1'b0, none},
      '{mk(OpReadBin, 16'd128, 0, 0, 0, 0), 1'b0, none},
      '{mk(OpReadBin, 16'hFFFF, 0, 0, 0, 0), 1'b0, none},
      '{mk(OpClear, 0, 0, 0, 0, 0), 1'b0, none},
      '{mk(OpReadBin, 16'd0, 0, 0, 0, 0), 1'b0, none},
      '{mk(OpEndGen, 0, 0, 0, 0, 0), 1'b0, none},
      '{mk(OpUnused6, 0, 0, 0, 0, 0), 1'b0, none},
      '{mk(OpMove, 16'd0, 0, 0, 0, 16'hFFFF), 1'b0, none}
    };

    phases[0] = '{15, 32'd300, 32'd3277, 32'd14654, 32'd655360};
    phases[1] = '{85, 32'd1, 32'd65535, 32'd65535, 32'd1};
    phases[2] = '{0, 32'd0, 32'd0, 32'd0, 32'hFFFFFFFF};
    phases[3] = '{0, 32'h1FFFF, 32'd1000, 32'd30000, 32'd2000000};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) issue(rows[i].item, rows[i].typed, rows[i].want);

    foreach (phases[p]) begin
      drain();
      write_cfg(CfgTarget, phases[p].target);
      write_cfg(CfgTimeStep, phases[p].dt);
      write_cfg(CfgSqrtStep, phases[p].sqdt);
      write_cfg(CfgHistMax, phases[p].rmax);
      idle_pct = phases[p].idle;
      repeat (100) issue(random_item(), 1'b0, none);
    end

    // time step, sqrt step and hist max back to defaults, target 65536, then a last few commands
    drain();
    write_cfg(CfgTarget, 32'd65536);
    write_cfg(CfgTimeStep, 32'(TimeStepRst));
    write_cfg(CfgSqrtStep, 32'(SqrtStepRst));
    write_cfg(CfgHistMax, 32'(HistMaxRst));
    idle_pct = 0;
    issue(mk(OpLoad, 0, 0, 0, 0, 0), 1'b0, none);
    issue(mk(OpMove, 16'd5, 0, 0, 0, 16'd0), 1'b0, none);
    issue(mk(OpReadBin, 16'd1, 0, 0, 0, 0), 1'b0, none);
    issue(mk(OpClear, 0, 0, 0, 0, 0), 1'b0, none);

    drain();
    repeat (50) @(posedge clk_i);
    if (fails == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
